// ----- design/bel_pkg.sv -----
// shared types, constants and helper functions for the breakpoint envelope lookup
package bel_pkg;

    localparam int DEF_MAX_SEGMENTS = 16;

    localparam int LEVEL_W = 32;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 3;
    localparam int AMT_W   = 16;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 9;   // holds segment counts up to 256
    localparam int SEG_W   = 8;
    localparam int SUM_W   = 40;  // running sum of up to 256 durations

    localparam int DIV_NUM_W = 66;
    localparam int DIV_DEN_W = 34;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STEP      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NUMERICAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WELCH     = 3'd5;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [23:0] LN2_Q24    = 24'd11629080;
    localparam logic [63:0] LN2_RECIP_64 = (64'd1 << 48) / 64'd11629080;
    localparam logic [24:0] LN2_RECIP  = LN2_RECIP_64[24:0];
    localparam logic [3:0]  EXP_TERMS  = 4'd10;

    typedef struct packed {
        logic                     act;
        logic                     hit;
        logic [TIME_W-1:0]        t;
        logic [SUM_W-1:0]         stage;
        logic [SUM_W-1:0]         last;
        logic [SEG_W-1:0]         seg;
        logic [LEVEL_W-1:0]       l0;
        logic [LEVEL_W-1:0]       l1;
        logic [KIND_W-1:0]        kind;
        logic [AMT_W-1:0]         amt;
    } t_tok;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CHAIN,
        T_CURVE,
        T_HOLD
    } t_top_state;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DECIDE,
        C_POS_WAIT,
        C_P_MUL,
        C_EXPA_WAIT,
        C_EXPB_GO,
        C_EXPB_WAIT,
        C_FRAC_GO,
        C_FRAC_WAIT,
        C_MUL_LO,
        C_MUL_HI,
        C_LIN_GO,
        C_LIN_WAIT,
        C_SHIFT,
        C_FINISH,
        C_DONE
    } t_curve_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_K,
        E_RED,
        E_MUL,
        E_REC,
        E_FIX,
        E_OUT
    } t_exp_state;

    // floor(2^32 / m) for the series terms
    function automatic logic [32:0] div_recip(input logic [3:0] m);
        logic [63:0] r;
        case (m)
            4'd1:    r = (64'd1 << 32) / 64'd1;
            4'd2:    r = (64'd1 << 32) / 64'd2;
            4'd3:    r = (64'd1 << 32) / 64'd3;
            4'd4:    r = (64'd1 << 32) / 64'd4;
            4'd5:    r = (64'd1 << 32) / 64'd5;
            4'd6:    r = (64'd1 << 32) / 64'd6;
            4'd7:    r = (64'd1 << 32) / 64'd7;
            4'd8:    r = (64'd1 << 32) / 64'd8;
            4'd9:    r = (64'd1 << 32) / 64'd9;
            4'd10:   r = (64'd1 << 32) / 64'd10;
            default: r = 64'd0;
        endcase
        return r[32:0];
    endfunction

endpackage

// ----- design/bel_cell.sv -----
// one segment cell: stores a breakpoint and advances the lookup token by one segment
module bel_cell import bel_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [LEVEL_W-1:0] i_wr_level,
    input  logic [TIME_W-1:0]  i_wr_dur,
    input  logic [KIND_W-1:0]  i_wr_kind,
    input  logic [AMT_W-1:0]   i_wr_amt,
    input  logic [CNT_W-1:0]   i_n,
    input  logic [LEVEL_W-1:0] i_level_next,
    input  t_tok               i_tok,
    output t_tok               o_tok,
    output logic [LEVEL_W-1:0] o_level
);

    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_dur;
    logic [KIND_W-1:0]  r_kind;
    logic [AMT_W-1:0]   r_amt;
    t_tok               r_tok;
    t_tok               n_tok;
    logic               take;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_level <= i_wr_level;
            r_dur   <= i_wr_dur;
            r_kind  <= i_wr_kind;
            r_amt   <= i_wr_amt;
        end
    end

    // walk on while the running sum is still short of the time
    assign take = i_tok.act && (i_tok.stage < SUM_W'(i_tok.t)) && (CNT_W'(IDX) < i_n);

    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.hit   = 1'b1;
            n_tok.last  = i_tok.stage;
            n_tok.stage = i_tok.stage + SUM_W'(r_dur);
            n_tok.seg   = SEG_W'(IDX);
            n_tok.l0    = r_level;
            n_tok.l1    = i_level_next;
            n_tok.kind  = r_kind;
            n_tok.amt   = r_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.act <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_level = r_level;

endmodule

// ----- design/bel_div.sv -----
// restoring divider, one quotient bit per cycle
module bel_div import bel_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [6:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    assign shifted = {r_rem, r_q[DIV_NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DIV_NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? DIV_DEN_W'(shifted - {1'b0, r_den}) : shifted[DIV_DEN_W-1:0];
                r_q   <= {r_q[DIV_NUM_W-2:0], fits};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ----- design/bel_exp.sv -----
// exp(-y) in Q1.30 for y in Q.24: range reduction by ln2, nested series, final shift
module bel_exp import bel_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_y,
    output logic        o_done,
    output logic [30:0] o_e
);

    t_exp_state  r_state;
    t_exp_state  n_state;
    logic [29:0] r_y;
    logic [62:0] r_prod;
    logic [6:0]  r_k;
    logic [29:0] r_r;
    logic [30:0] r_acc;
    logic [29:0] r_t;
    logic [3:0]  r_m;
    logic [30:0] r_e;

    logic [6:0]  kq;
    logic [30:0] kl;
    logic [30:0] remv;
    logic        red_up;
    logic [30:0] rem_fix;
    logic [29:0] qe;
    logic [33:0] chk;
    logic [29:0] q;
    logic [60:0] ra;

    assign kq      = r_prod[54:48];
    assign kl      = 31'(kq * LN2_Q24);
    assign remv    = {1'b0, r_y} - kl;
    assign red_up  = remv >= 31'(LN2_Q24);
    assign rem_fix = red_up ? remv - 31'(LN2_Q24) : remv;
    assign ra      = r_r * r_acc;
    assign qe      = r_prod[61:32];
    assign chk     = {4'b0, r_t} - 34'(qe * r_m);
    assign q       = (chk >= 34'(r_m)) ? qe + 30'd1 : qe;

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE:  if (i_start) n_state = E_K;
            E_K:     n_state = E_RED;
            E_RED:   n_state = E_MUL;
            E_MUL:   n_state = E_REC;
            E_REC:   n_state = E_FIX;
            E_FIX:   n_state = (r_m == 4'd1) ? E_OUT : E_MUL;
            E_OUT:   n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                if (i_start) r_y <= i_y;
            end
            E_K: begin
                r_prod <= 63'(r_y * LN2_RECIP);
            end
            E_RED: begin
                r_k   <= red_up ? kq + 7'd1 : kq;
                r_r   <= {rem_fix[23:0], 6'b0};
                r_acc <= Q30_ONE;
                r_m   <= EXP_TERMS;
            end
            E_MUL: begin
                r_t <= ra[59:30];
            end
            E_REC: begin
                r_prod <= 63'(r_t * div_recip(r_m));
            end
            E_FIX: begin
                r_acc <= Q30_ONE - 31'(q);
                r_m   <= r_m - 4'd1;
            end
            E_OUT: begin
                r_e <= (r_k >= 7'd64) ? 31'd0 : (r_acc >> r_k[5:0]);
            end
            default: begin
                r_y <= r_y;
            end
        endcase
    end

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == E_OUT);
        end
    end

    assign o_done = r_done;
    assign o_e    = r_e;

endmodule

// ----- design/bel_curve.sv -----
// segment evaluation: step, linear and numerical curve interpolation
module bel_curve import bel_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_tok               i_tok,
    input  logic [LEVEL_W-1:0] i_level0,
    output logic               o_done,
    output logic [LEVEL_W-1:0] o_level,
    output logic [IDX_W-1:0]   o_seg
);

    t_curve_state r_state;
    t_curve_state n_state;
    t_tok         r_tok;
    logic [LEVEL_W-1:0] r_level0;
    logic [30:0]  r_pos;
    logic [29:0]  r_p;
    logic [30:0]  r_ea;
    logic [30:0]  r_e2;
    logic [31:0]  r_x;
    logic         r_lin;
    logic [64:0]  r_prod;
    logic [32:0]  r_part;
    logic [LEVEL_W-1:0] r_res;
    logic [IDX_W-1:0]   r_seg;

    logic [31:0]  span;
    logic [31:0]  off;
    logic         past_end;
    logic         step_like;
    logic         numeric;
    logic [15:0]  cm;
    logic [29:0]  a_arg;
    logic [32:0]  diff;
    logic         neg;
    logic [32:0]  mag;
    logic [46:0]  pc;
    logic [30:0]  num_f;
    logic [30:0]  den_f;
    logic [33:0]  res_fin;
    logic [48:0]  pp_lo;
    logic [48:0]  pp_hi;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 exp_start;
    logic [29:0]          exp_y;
    logic                 exp_done;
    logic [30:0]          exp_e;

    bel_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    bel_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_y     (exp_y),
        .o_done  (exp_done),
        .o_e     (exp_e)
    );

    assign span      = 32'(r_tok.stage - r_tok.last);
    assign off       = 32'(SUM_W'(r_tok.t) - r_tok.last);
    assign past_end  = r_tok.stage < SUM_W'(r_tok.t);
    assign cm        = r_tok.amt[AMT_W-1] ? (~r_tok.amt + 16'd1) : r_tok.amt;
    assign a_arg     = {cm, 14'b0};
    assign step_like = (span == 32'd0) || (r_tok.kind == KIND_STEP) || (r_tok.kind > KIND_WELCH);
    assign numeric   = (r_tok.kind == KIND_NUMERICAL) && (cm > 16'd1);
    assign diff      = {r_tok.l1[LEVEL_W-1], r_tok.l1} - {r_tok.l0[LEVEL_W-1], r_tok.l0};
    assign neg       = diff[32];
    assign mag       = neg ? (~diff + 33'd1) : diff;
    assign pc        = r_pos * cm;
    // positive curvature measures from the far end of the exponential
    assign num_f     = r_tok.amt[AMT_W-1] ? (Q30_ONE - r_e2)
                     : ((r_e2 >= r_ea) ? (r_e2 - r_ea) : 31'd0);
    assign den_f     = Q30_ONE - r_ea;
    assign res_fin   = neg ? ({{2{r_tok.l0[LEVEL_W-1]}}, r_tok.l0} - {1'b0, r_part})
                           : ({{2{r_tok.l0[LEVEL_W-1]}}, r_tok.l0} + {1'b0, r_part});
    assign pp_lo     = mag * r_x[15:0];
    assign pp_hi     = mag * r_x[31:16];

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        exp_start = 1'b0;
        exp_y     = '0;
        case (r_state)
            C_IDLE: begin
                if (i_start) n_state = C_DECIDE;
            end
            C_DECIDE: begin
                if (!r_tok.hit || past_end || step_like) begin
                    n_state = C_DONE;
                end else if (numeric) begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'({off, 30'b0});
                    div_den   = DIV_DEN_W'(span);
                    n_state   = C_POS_WAIT;
                end else begin
                    n_state = C_MUL_LO;
                end
            end
            C_POS_WAIT: begin
                if (div_done) n_state = C_P_MUL;
            end
            C_P_MUL: begin
                exp_start = 1'b1;
                exp_y     = a_arg;
                n_state   = C_EXPA_WAIT;
            end
            C_EXPA_WAIT: begin
                if (exp_done) n_state = C_EXPB_GO;
            end
            C_EXPB_GO: begin
                exp_start = 1'b1;
                exp_y     = r_tok.amt[AMT_W-1] ? r_p : (a_arg - r_p);
                n_state   = C_EXPB_WAIT;
            end
            C_EXPB_WAIT: begin
                if (exp_done) n_state = C_FRAC_GO;
            end
            C_FRAC_GO: begin
                if (den_f == 31'd0) begin
                    n_state = C_MUL_LO;
                end else begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'({num_f, 30'b0});
                    div_den   = DIV_DEN_W'(den_f);
                    n_state   = C_FRAC_WAIT;
                end
            end
            C_FRAC_WAIT: begin
                if (div_done) n_state = C_MUL_LO;
            end
            C_MUL_LO: n_state = C_MUL_HI;
            C_MUL_HI: n_state = r_lin ? C_LIN_GO : C_SHIFT;
            C_LIN_GO: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(r_prod);
                div_den   = DIV_DEN_W'(span);
                n_state   = C_LIN_WAIT;
            end
            C_LIN_WAIT: begin
                if (div_done) n_state = C_FINISH;
            end
            C_SHIFT:  n_state = C_FINISH;
            C_FINISH: n_state = C_DONE;
            C_DONE:   n_state = C_IDLE;
            default:  n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_tok    <= i_tok;
                    r_level0 <= i_level0;
                end
            end
            C_DECIDE: begin
                r_seg <= r_tok.hit ? IDX_W'(r_tok.seg) : '0;
                r_x   <= off;
                r_lin <= 1'b1;
                if (!r_tok.hit) begin
                    r_res <= r_level0;
                end else if (past_end || step_like) begin
                    r_res <= r_tok.l1;
                end
            end
            C_POS_WAIT: begin
                if (div_done) r_pos <= div_quo[30:0];
            end
            C_P_MUL: begin
                r_p <= pc[45:16];
            end
            C_EXPA_WAIT: begin
                if (exp_done) r_ea <= exp_e;
            end
            C_EXPB_WAIT: begin
                if (exp_done) r_e2 <= exp_e;
            end
            C_FRAC_WAIT: begin
                if (div_done) begin
                    r_lin <= 1'b0;
                    r_x   <= (div_quo > DIV_NUM_W'(Q30_ONE)) ? 32'(Q30_ONE)
                                                              : 32'(div_quo[30:0]);
                end
            end
            C_MUL_LO: begin
                r_prod <= 65'(pp_lo);
            end
            C_MUL_HI: begin
                r_prod <= r_prod + {pp_hi, 16'b0};
            end
            C_LIN_WAIT: begin
                if (div_done) r_part <= div_quo[32:0];
            end
            C_SHIFT: begin
                r_part <= r_prod[62:30];
            end
            C_FINISH: begin
                r_res <= res_fin[LEVEL_W-1:0];
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_done  = (r_state == C_DONE);
    assign o_level = r_res;
    assign o_seg   = r_seg;

endmodule

// ----- design/breakpoint_envelope_lookup_core.sv -----
// breakpoint envelope lookup: write beats fill the cells, lookup beats yield one level each
// a lookup walks the cell chain, then the curve unit evaluates the segment: step directly,
// linear through one divide, and the numerical curve through two divides and two exp
// evaluations
// one lookup is in flight at a time; the next is taken while its result waits at the output
// sync active-low reset clears control state and num_segments; tables undefined until written
module breakpoint_envelope_lookup_core import bel_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [IDX_W-1:0]   i_point_index,
    input  logic [LEVEL_W-1:0] i_point_level,
    input  logic [TIME_W-1:0]  i_segment_duration,
    input  logic [KIND_W-1:0]  i_curve_kind,
    input  logic [AMT_W-1:0]   i_curve_amount,
    input  logic [TIME_W-1:0]  i_lookup_time,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [LEVEL_W-1:0] o_envelope_level,
    output logic [IDX_W-1:0]   o_segment_found,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_data
);

    t_top_state         r_state;
    t_top_state         n_state;
    logic [IDX_W-1:0]   r_num_seg;
    logic [LEVEL_W-1:0] r_last_level;
    logic               r_ovalid;
    logic [LEVEL_W-1:0] r_olevel;
    logic [IDX_W-1:0]   r_oseg;

    logic               accept;
    logic               wr_beat;
    logic               lookup_beat;
    logic [CNT_W-1:0]   n_used;
    logic               out_free;
    logic               load_out;
    logic               curve_start;
    logic               curve_done;
    logic [LEVEL_W-1:0] curve_level;
    logic [IDX_W-1:0]   curve_seg;
    t_tok               head_tok;

    t_tok               tok [0:MAX_SEGMENTS];
    logic [LEVEL_W-1:0] lvl [0:MAX_SEGMENTS];

    assign accept      = i_valid && !o_stall;
    assign wr_beat     = accept && (i_opcode == OP_WRITE);
    assign lookup_beat = accept && (i_opcode == OP_LOOKUP);
    assign o_cfg_ready = 1'b1;
    assign n_used      = (CNT_W'(r_num_seg) > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                                   : CNT_W'(r_num_seg);

    always_comb begin
        head_tok     = '0;
        head_tok.act = lookup_beat;
        head_tok.t   = i_lookup_time;
    end
    assign tok[0] = head_tok;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            bel_cell #(.IDX(g)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_wr_en      (wr_beat && (CNT_W'(i_point_index) == CNT_W'(g))),
                .i_wr_level   (i_point_level),
                .i_wr_dur     (i_segment_duration),
                .i_wr_kind    (i_curve_kind),
                .i_wr_amt     (i_curve_amount),
                .i_n          (n_used),
                .i_level_next (lvl[g+1]),
                .i_tok        (tok[g]),
                .o_tok        (tok[g+1]),
                .o_level      (lvl[g])
            );
        end
    endgenerate

    // the final level has no segment of its own
    always_ff @(posedge i_clk) begin
        if (wr_beat && (CNT_W'(i_point_index) == CNT_W'(MAX_SEGMENTS))) begin
            r_last_level <= i_point_level;
        end
    end
    assign lvl[MAX_SEGMENTS] = r_last_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_seg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_seg <= i_cfg_data;
        end
    end

    bel_curve u_curve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (curve_start),
        .i_tok    (tok[MAX_SEGMENTS]),
        .i_level0 (lvl[0]),
        .o_done   (curve_done),
        .o_level  (curve_level),
        .o_seg    (curve_seg)
    );

    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state     = r_state;
        curve_start = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            T_IDLE: begin
                if (lookup_beat) n_state = T_CHAIN;
            end
            T_CHAIN: begin
                if (tok[MAX_SEGMENTS].act) begin
                    curve_start = 1'b1;
                    n_state     = T_CURVE;
                end
            end
            T_CURVE: begin
                if (curve_done) begin
                    load_out = out_free;
                    n_state  = out_free ? T_IDLE : T_HOLD;
                end
            end
            T_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_olevel <= curve_level;
            r_oseg   <= curve_seg;
        end
    end

    assign o_stall          = (r_state != T_IDLE);
    assign o_valid          = r_ovalid;
    assign o_envelope_level = r_olevel;
    assign o_segment_found  = r_oseg;

    a_tail_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[MAX_SEGMENTS].act |-> (r_state == T_CHAIN))
        else $error("lookup token left the chain outside the chain phase");

    a_done_in_curve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        curve_done |-> (r_state == T_CURVE))
        else $error("curve result arrived with no lookup waiting for it");

    a_lookup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lookup_beat |=> o_stall)
        else $error("input not stalled after a lookup beat");

endmodule
